// File: src/btp_pkg.sv
// Shared types, constants and helper functions for the binary thinning pass unit.
// Used by binary_thinning_pass_unit and its checker; depends on nothing.
package btp_pkg;

   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_WIDTH  = 256;

   localparam logic [7:0] DEF_THRESHOLD = 8'd127;
   localparam logic [7:0] PIX_ON        = 8'd255;
   localparam logic [7:0] PIX_OFF       = 8'd0;
   localparam int         MIN_NEIGHBORS = 2;
   localparam int         MAX_NEIGHBORS = 6;
   localparam logic [3:0] NB_COUNT      = 4'd9;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_WIDTH     = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MARK,
      ST_EVAL,
      ST_DEL,
      ST_DRAIN,
      ST_READ,
      ST_FETCH
   } state_type;

   // Row offset + 1 of window tap k: P2,P3,...,P9 then center.
   function automatic logic [1:0] nb_dr(input logic [3:0] k);
      logic [1:0] r;
      unique case (k)
         4'd0, 4'd1, 4'd7: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd2;
         default:          r = 2'd1;
      endcase
      return r;
   endfunction

   // Column offset + 1 of window tap k.
   function automatic logic [1:0] nb_dc(input logic [3:0] k);
      logic [1:0] r;
      unique case (k)
         4'd1, 4'd2, 4'd3: r = 2'd2;
         4'd5, 4'd6, 4'd7: r = 2'd0;
         default:          r = 2'd1;
      endcase
      return r;
   endfunction

   // win[0..7] = P2..P9, win[8] = center.
   function automatic logic can_delete(input logic [8:0] win, input logic second);
      logic [3:0] np;
      logic [3:0] tp;
      logic       cond;
      np = 4'd0;
      tp = 4'd0;
      for (int k = 0; k < 8; k++) begin
         np = np + 4'(win[k]);
         if (!win[k] && win[(k + 1) % 8]) tp = tp + 4'd1;
      end
      if (!second)
         cond = !(win[0] & win[2] & win[4]) && !(win[2] & win[4] & win[6]);
      else
         cond = !(win[0] & win[2] & win[6]) && !(win[0] & win[4] & win[6]);
      return win[8] && (np >= 4'(MIN_NEIGHBORS)) && (np <= 4'(MAX_NEIGHBORS))
             && (tp == 4'd1) && cond;
   endfunction

endpackage

// File: src/binary_thinning_pass_unit.sv
// Top level of the binary thinning pass unit: bitmap and mark memories,
// load/thin/readout sequencer. Depends on btp_pkg.
//
// Usage:
//  - req_ channel: a word is taken when start is high and busy is low.
//    req_operation load writes the next pixel (raster order), fetch reads
//    the next thinned pixel. A fetch while loading is dropped.
//  - rsp_ channel: one word per fetch, on rsp_valid for one cycle; the
//    receiver cannot stall it. rsp_last_pixel marks the final pixel.
//  - csr_ channel: always ready; index 0 threshold, 1 height, 2 width.
//    Writing a size restarts loading at pixel zero.
// Throughput and latency:
//  - Load: one pixel per cycle.
//  - After the last load busy stays high for two sub-passes if the image is at
//    least 3x3 (else readout follows at once); each sub-pass marks every interior
//    pixel (nine reads on the single bitmap read port plus evaluate), then runs
//    a delete sweep over the interior pixels, then a drain state.
//  - Fetch: result in the cycle after acceptance; busy is high while it is out.
// Reset: threshold 127, size at the maximum, loading from pixel zero;
// memory contents are not cleared.
module binary_thinning_pass_unit #(
   parameter int MAX_HEIGHT = btp_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = btp_pkg::DEF_MAX_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_pixel_value,
   output logic       rsp_valid,
   output logic [7:0] rsp_result_pixel,
   output logic       rsp_last_pixel,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);
   import btp_pkg::*;

   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RA = $clog2(MAX_HEIGHT);
   localparam int CA = $clog2(MAX_WIDTH);
   localparam int AW = RA + CA;
   localparam int DEPTH = 2 ** AW;

   state_type       state_ff, state_in;
   logic [HW-1:0]   row_ff, row_in;
   logic [WW-1:0]   col_ff, col_in;
   logic [HW-1:0]   h_ff, h_in;
   logic [WW-1:0]   w_ff, w_in;
   logic [7:0]      thr_ff, thr_in;
   logic [3:0]      nb_ff, nb_in;
   logic            sub_ff, sub_in;
   logic [8:0]      win_ff, win_in;
   logic            dv_ff, dv_in;
   logic [AW-1:0]   da_ff, da_in;

   logic            bm_mem [DEPTH];
   logic            mk_mem [DEPTH];
   logic            bit_rd_ff;
   logic            mk_rd_ff;

   logic            bm_we, bm_wdata, mk_we, mk_wdata;
   logic [AW-1:0]   bm_waddr, bm_raddr, mk_waddr, mk_raddr;

   logic [AW-1:0]   pos_addr, nb_addr;
   logic [HW-1:0]   nb_row;
   logic [WW-1:0]   nb_col;
   logic [3:0]      nb_idx;
   logic            last_int, accept, cfg_we;
   logic [HW-1:0]   h_clamp;
   logic [WW-1:0]   w_clamp;

   assign accept    = start && !busy;
   assign cfg_we    = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   assign pos_addr = {row_ff[RA-1:0], col_ff[CA-1:0]};
   assign nb_idx   = (nb_ff < NB_COUNT) ? nb_ff : 4'd0;
   assign nb_row   = row_ff + HW'(nb_dr(nb_idx)) - HW'(1);
   assign nb_col   = col_ff + WW'(nb_dc(nb_idx)) - WW'(1);
   assign nb_addr  = {nb_row[RA-1:0], nb_col[CA-1:0]};
   assign last_int = (col_ff == w_ff - WW'(2)) && (row_ff == h_ff - HW'(2));

   assign h_clamp = (csr_wdata == 9'd0) ? HW'(1) :
                    (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(csr_wdata);
   assign w_clamp = (csr_wdata == 9'd0) ? WW'(1) :
                    (32'(csr_wdata) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(csr_wdata);

   assign busy             = !(state_ff == ST_LOAD || state_ff == ST_READ);
   assign rsp_valid        = (state_ff == ST_FETCH);
   assign rsp_result_pixel = bit_rd_ff ? PIX_ON : PIX_OFF;
   assign rsp_last_pixel   = (row_ff == h_ff - HW'(1)) && (col_ff == w_ff - WW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         row_ff   <= '0;
         col_ff   <= '0;
         h_ff     <= HW'(MAX_HEIGHT);
         w_ff     <= WW'(MAX_WIDTH);
         thr_ff   <= DEF_THRESHOLD;
         nb_ff    <= '0;
         sub_ff   <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         h_ff     <= h_in;
         w_ff     <= w_in;
         thr_ff   <= thr_in;
         nb_ff    <= nb_in;
         sub_ff   <= sub_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      da_ff  <= da_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      bit_rd_ff <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (mk_we) mk_mem[mk_waddr] <= mk_wdata;
      mk_rd_ff <= mk_mem[mk_raddr];
   end

   always_comb begin
      logic [HW-1:0] lrow;
      logic [WW-1:0] lcol;
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      h_in     = h_ff;
      w_in     = w_ff;
      thr_in   = thr_ff;
      nb_in    = nb_ff;
      sub_in   = sub_ff;
      win_in   = win_ff;
      dv_in    = 1'b0;
      da_in    = pos_addr;
      bm_we    = 1'b0;
      bm_wdata = 1'b0;
      bm_waddr = pos_addr;
      bm_raddr = (state_ff == ST_MARK) ? nb_addr : pos_addr;
      mk_we    = 1'b0;
      mk_wdata = can_delete(win_ff, sub_ff);
      mk_waddr = pos_addr;
      mk_raddr = pos_addr;
      lrow     = (state_ff == ST_READ) ? HW'(0) : row_ff;
      lcol     = (state_ff == ST_READ) ? WW'(0) : col_ff;

      unique case (state_ff)
         ST_LOAD, ST_READ: begin
            if (accept && req_operation == OP_LOAD) begin
               bm_we    = 1'b1;
               bm_waddr = {lrow[RA-1:0], lcol[CA-1:0]};
               bm_wdata = (req_pixel_value > thr_ff);
               if (lcol == w_ff - WW'(1)) begin
                  col_in = '0;
                  row_in = lrow + HW'(1);
                  if (lrow == h_ff - HW'(1)) begin
                     if (h_ff >= HW'(3) && w_ff >= WW'(3)) begin
                        state_in = ST_MARK;
                        row_in   = HW'(1);
                        col_in   = WW'(1);
                        nb_in    = '0;
                        sub_in   = 1'b0;
                     end else begin
                        state_in = ST_READ;
                        row_in   = '0;
                     end
                  end else begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  col_in   = lcol + WW'(1);
                  row_in   = lrow;
                  state_in = ST_LOAD;
               end
            end else if (accept && state_ff == ST_READ) begin
               state_in = ST_FETCH;
            end
         end
         ST_MARK: begin
            if (nb_ff != 4'd0) win_in[nb_ff - 4'd1] = bit_rd_ff;
            if (nb_ff == NB_COUNT) state_in = ST_EVAL;
            else nb_in = nb_ff + 4'd1;
         end
         ST_EVAL: begin
            mk_we = 1'b1;
            nb_in = '0;
            if (last_int) begin
               state_in = ST_DEL;
               row_in   = HW'(1);
               col_in   = WW'(1);
            end else begin
               state_in = ST_MARK;
               if (col_ff == w_ff - WW'(2)) begin
                  col_in = WW'(1);
                  row_in = row_ff + HW'(1);
               end else begin
                  col_in = col_ff + WW'(1);
               end
            end
         end
         ST_DEL: begin
            dv_in = 1'b1;
            if (last_int) begin
               state_in = ST_DRAIN;
            end else if (col_ff == w_ff - WW'(2)) begin
               col_in = WW'(1);
               row_in = row_ff + HW'(1);
            end else begin
               col_in = col_ff + WW'(1);
            end
         end
         ST_DRAIN: begin
            nb_in = '0;
            if (!sub_ff) begin
               state_in = ST_MARK;
               sub_in   = 1'b1;
               row_in   = HW'(1);
               col_in   = WW'(1);
            end else begin
               state_in = ST_READ;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_FETCH: begin
            if (rsp_last_pixel) begin
               state_in = ST_LOAD;
               row_in   = '0;
               col_in   = '0;
            end else begin
               state_in = ST_READ;
               if (col_ff == w_ff - WW'(1)) begin
                  col_in = '0;
                  row_in = row_ff + HW'(1);
               end else begin
                  col_in = col_ff + WW'(1);
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (dv_ff && mk_rd_ff) begin
         bm_we    = 1'b1;
         bm_waddr = da_ff;
         bm_wdata = 1'b0;
      end

      if (cfg_we) begin
         if (csr_index == CSR_THRESHOLD) begin
            thr_in = csr_wdata[7:0];
         end else if (csr_index == CSR_HEIGHT || csr_index == CSR_WIDTH) begin
            if (csr_index == CSR_HEIGHT) h_in = h_clamp;
            else w_in = w_clamp;
            state_in = ST_LOAD;
            row_in   = '0;
            col_in   = '0;
         end
      end
   end

endmodule

// File: src/btp_checker.sv
// Port-level checker for binary_thinning_pass_unit and its bind statement.
// Depends on btp_pkg.
module btp_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_result_pixel,
   input logic       rsp_last_pixel
);
   import btp_pkg::*;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result word outside busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result words");

   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_pixel == PIX_ON || rsp_result_pixel == PIX_OFF))
      else $error("result pixel not 0 or 255");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |=> !busy) else $error("busy after final word");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !busy) else $error("busy after reset");

endmodule

bind binary_thinning_pass_unit btp_checker u_btp_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_pixel (rsp_result_pixel),
   .rsp_last_pixel   (rsp_last_pixel)
);

// File: verif/binary_thinning_pass_unit_tb.sv
// Testbench for binary_thinning_pass_unit: loads small random images, fetches the
// thinned result and checks every word against a local Zhang-Suen iteration model.
// Depends on btp_pkg and the binary_thinning_pass_unit RTL only.
module binary_thinning_pass_unit_tb;
   import btp_pkg::*;

   typedef struct {
      logic [7:0] pix;
      logic       last;
   } pixel_word_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_WORD, ROW_CHECKED} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   idx;
      logic         op;
      logic [8:0]   data;
      logic [7:0]   exp_pix;
      logic         exp_last;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_operation = OP_LOAD;
   logic [7:0] req_pixel_value = 8'd0;
   logic       rsp_valid;
   logic [7:0] rsp_result_pixel;
   logic       rsp_last_pixel;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_THRESHOLD;
   logic [8:0] csr_wdata = 9'd0;

   binary_thinning_pass_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // thinning model state
   bit          bitmap[65536];
   bit          marks[65536];
   int unsigned thr_m = 127, rows_m = 256, cols_m = 256;
   int unsigned load_idx, fetch_idx;
   bit          loading = 1'b1;

   pixel_word_type pixel_expect_q[$];
   int          errors;
   int          word_count;
   int          idle_pct;

   function automatic int unsigned clamp_size(input logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic void thin_subpass(input bit second);
      bit p[9];
      int np, tp;
      bit del;
      if (rows_m < 3 || cols_m < 3) return;
      for (int r = 1; r + 1 < rows_m; r++)
         for (int c = 1; c + 1 < cols_m; c++) begin
            del = 1'b0;
            if (bitmap[r*cols_m + c]) begin
               p[0] = bitmap[(r-1)*cols_m + c];
               p[1] = bitmap[(r-1)*cols_m + c + 1];
               p[2] = bitmap[r*cols_m + c + 1];
               p[3] = bitmap[(r+1)*cols_m + c + 1];
               p[4] = bitmap[(r+1)*cols_m + c];
               p[5] = bitmap[(r+1)*cols_m + c - 1];
               p[6] = bitmap[r*cols_m + c - 1];
               p[7] = bitmap[(r-1)*cols_m + c - 1];
               p[8] = p[0];
               np = 0;
               tp = 0;
               for (int k = 0; k < 8; k++) begin
                  np += p[k];
                  if (!p[k] && p[k+1]) tp++;
               end
               if (np >= MIN_NEIGHBORS && np <= MAX_NEIGHBORS && tp == 1) begin
                  if (!second) del = !(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6]);
                  else         del = !(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]);
               end
            end
            marks[r*cols_m + c] = del;
         end
      for (int r = 1; r + 1 < rows_m; r++)
         for (int c = 1; c + 1 < cols_m; c++)
            if (marks[r*cols_m + c]) bitmap[r*cols_m + c] = 1'b0;
   endfunction

   function automatic void thin_model_step(input logic op, input logic [7:0] val,
                                           output bit got, output pixel_word_type w);
      int unsigned total;
      total = rows_m * cols_m;
      got = 1'b0;
      w.pix = PIX_OFF;
      w.last = 1'b0;
      if (op == OP_LOAD) begin
         if (!loading) begin
            loading = 1'b1;
            load_idx = 0;
            fetch_idx = 0;
         end
         bitmap[load_idx] = (val > thr_m);
         load_idx++;
         if (load_idx >= total) begin
            thin_subpass(1'b0);
            thin_subpass(1'b1);
            loading = 1'b0;
            load_idx = 0;
            fetch_idx = 0;
         end
      end else if (!loading) begin
         got = 1'b1;
         w.pix = bitmap[fetch_idx] ? PIX_ON : PIX_OFF;
         w.last = (fetch_idx + 1 >= total);
         fetch_idx++;
         if (w.last) begin
            loading = 1'b1;
            load_idx = 0;
            fetch_idx = 0;
         end
      end
   endfunction

   // called just after a falling edge; returns just after a falling edge, start held unless an idle gap dropped it
   task automatic send_word(input logic op, input logic [7:0] val, input bit typed,
                            input pixel_word_type typed_w);
      bit             got;
      pixel_word_type w;
      start = 1'b1;
      req_operation = op;
      req_pixel_value = val;
      while (busy) @(negedge clock);
      thin_model_step(op, val, got, w);
      if (got) pixel_expect_q.push_back(typed ? typed_w : w);
      if (op == OP_LOAD || got) word_count++;
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pixel_expect_q.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [8:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      while (!csr_ready) @(negedge clock);
      case (idx)
         CSR_THRESHOLD: thr_m = data[7:0];
         CSR_HEIGHT, CSR_WIDTH: begin
            if (idx == CSR_HEIGHT) rows_m = clamp_size(data);
            else cols_m = clamp_size(data);
            loading = 1'b1;
            load_idx = 0;
            fetch_idx = 0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_value(input bit on);
      if (on && thr_m < 255) return 8'($urandom_range(thr_m + 1, 255));
      return 8'($urandom_range(0, thr_m));
   endfunction

   task automatic run_image(input bit reconfig);
      pixel_word_type none;
      int          total, fetches, dens;
      logic [8:0]  sz;
      none = '{PIX_OFF, 1'b0};
      if (reconfig) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0: csr_write(CSR_THRESHOLD, 9'd0);
            1: csr_write(CSR_THRESHOLD, 9'd255);
            default: csr_write(CSR_THRESHOLD, 9'($urandom_range(20, 235)));
         endcase
         case ($urandom_range(0, 19))
            0: begin csr_write(CSR_HEIGHT, 9'd511); csr_write(CSR_WIDTH, 9'd3); end
            1: begin csr_write(CSR_WIDTH, 9'd256); csr_write(CSR_HEIGHT, 9'd3); end
            2: begin csr_write(CSR_HEIGHT, 9'd0); csr_write(CSR_WIDTH, 9'($urandom_range(257, 511))); end
            3: begin csr_write(CSR_WIDTH, 9'd1); csr_write(CSR_HEIGHT, 9'd256); end
            default: begin
               sz = 9'($urandom_range(1, 12));
               csr_write(CSR_HEIGHT, sz);
               csr_write(CSR_WIDTH, 9'($urandom_range(1, 12)));
            end
         endcase
      end
      total = rows_m * cols_m;
      dens = $urandom_range(30, 90);
      if ($urandom_range(0, 9) == 0) begin
         for (int i = 0; i < $urandom_range(1, total); i++)
            send_word(OP_LOAD, pick_value($urandom_range(0, 99) < dens), 1'b0, none);
         wait_idle();
         csr_write(CSR_WIDTH, 9'(cols_m));
      end
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 30) == 0) send_word(OP_FETCH, 8'($urandom), 1'b0, none);
         send_word(OP_LOAD, pick_value($urandom_range(0, 99) < dens), 1'b0, none);
      end
      fetches = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total) : total;
      for (int i = 0; i < fetches; i++) begin
         if (reconfig && i == fetches / 2 && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            while (pixel_expect_q.size() != 0) @(negedge clock);
         end
         send_word(OP_FETCH, 8'($urandom), 1'b0, none);
      end
   endtask

   localparam int N_ROWS = 23;
   stim_row_type directed[N_ROWS] = '{
      '{ROW_CSR,     CSR_THRESHOLD, OP_LOAD,  9'd0,   PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_HEIGHT,    OP_LOAD,  9'd0,   PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_WIDTH,     OP_LOAD,  9'd3,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_FETCH, 9'd255, PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd0,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd1,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd255, PIX_OFF, 1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_OFF, 1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_ON,  1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_ON,  1'b1},
      '{ROW_CSR,     CSR_THRESHOLD, OP_LOAD,  9'd255, PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_HEIGHT,    OP_LOAD,  9'd1,   PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_WIDTH,     OP_LOAD,  9'd2,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd255, PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd128, PIX_OFF, 1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd7,   PIX_OFF, 1'b0},
      '{ROW_WORD,    CSR_THRESHOLD, OP_LOAD,  9'd200, PIX_OFF, 1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_OFF, 1'b0},
      '{ROW_CHECKED, CSR_THRESHOLD, OP_FETCH, 9'd0,   PIX_OFF, 1'b1},
      '{ROW_CSR,     CSR_THRESHOLD, OP_LOAD,  9'd127, PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_HEIGHT,    OP_LOAD,  9'd3,   PIX_OFF, 1'b0},
      '{ROW_CSR,     CSR_WIDTH,     OP_LOAD,  9'd3,   PIX_OFF, 1'b0}
   };

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_expect_q.size() == 0) begin
            if (errors < 10)
               $display("unexpected word: pixel %0d last %0b", rsp_result_pixel, rsp_last_pixel);
            errors++;
         end else begin
            pixel_word_type w;
            w = pixel_expect_q.pop_front();
            if (rsp_result_pixel !== w.pix || rsp_last_pixel !== w.last) begin
               if (errors < 10)
                  $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                           w.pix, w.last, rsp_result_pixel, rsp_last_pixel);
               errors++;
            end
         end
      end
   end

   initial begin
      #64000000;
      $display("binary_thinning_pass_unit_tb NOT OK");
      $finish;
   end

   initial begin
      int images;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_pct = 11;
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(directed[i].idx, directed[i].data);
         end else begin
            send_word(directed[i].op, directed[i].data[7:0], directed[i].kind == ROW_CHECKED,
                      '{directed[i].exp_pix, directed[i].exp_last});
         end
      end
      word_count = 0;
      images = 0;
      while (word_count < 2000) begin
         idle_pct = (word_count < 700) ? 11 : (word_count < 1400) ? 71 : 0;
         run_image(images == 0 || $urandom_range(0, 2) != 0);
         images++;
      end
      start = 1'b0;
      while (pixel_expect_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("binary_thinning_pass_unit_tb OK");
      else
         $display("binary_thinning_pass_unit_tb NOT OK");
      $finish;
   end

endmodule
